@@ rtl/masked_window_energy_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Masked window energy unit: assertion macros
// Shared assertion shorthands, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef MASKED_WINDOW_ENERGY_UNIT_DEFINES_SVH
`define MASKED_WINDOW_ENERGY_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mwe_pkg.sv @@
// ---------------------------------------------------------------------------
// Masked window energy package
// Sizes, types, state codes and helper functions shared by the unit.
// ---------------------------------------------------------------------------
package mwe_pkg;

  localparam int MAX_ROWS        = 1024;
  localparam int MAX_COLS        = 1024;
  localparam int MAX_HALF_WINDOW = 4;
  localparam int COEF_WIDTH      = 16;

  localparam int LINES     = 2 * MAX_HALF_WINDOW + 1;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int LINE_W    = $clog2(LINES + 1);
  localparam int WIN_W     = $clog2(LINES);
  localparam int HW_W      = 3;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DEPTH     = LINES * MAX_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SQ_W      = 2 * COEF_WIDTH;
  localparam int DIVS_W    = $clog2(LINES * LINES + 1);
  localparam int ACC_W     = SQ_W + DIVS_W;
  localparam int Q_W       = SQ_W;
  localparam int ROOT_W    = COEF_WIDTH;
  localparam int STEP_W    = $clog2(ACC_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = CFG_IDX_W'(2);

  typedef struct packed {
    logic [LINE_W-1:0] top_line;
    logic [COL_W-1:0]  left_col;
    logic [HW_W-1:0]   h;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
  } job_t;

  typedef struct packed {
    logic                         we;
    logic [ADDR_W-1:0]            addr;
    logic signed [COEF_WIDTH-1:0] detail;
    logic signed [COEF_WIDTH-1:0] coarser;
    logic                         sector;
  } mem_wr_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_CTR_RD, BK_CTR_CHK, BK_SUM, BK_DRAIN,
    BK_FIX1, BK_FIX2, BK_FIX3, BK_DIV, BK_SQRT, BK_OUT
  } back_state_t;

  function automatic logic [CFG_W-1:0] cfg_limit(input logic [CFG_W-1:0] v, input int max);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(max)) r = CFG_W'(max);
    return r;
  endfunction

  function automatic logic [LINE_W-1:0] line_add(input logic [LINE_W-1:0] a,
                                                 input logic [LINE_W-1:0] b);
    logic [LINE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LINE_W + 1)'(LINES)) s = s - (LINE_W + 1)'(LINES);
    return s[LINE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LINE_W-1:0] line,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'(line) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  function automatic logic [DIVS_W-1:0] side_sq(input logic [HW_W-1:0] h);
    logic [DIVS_W-1:0] s;
    s = DIVS_W'({h, 1'b1});
    return DIVS_W'(s * s);
  endfunction

endpackage

@@ rtl/mwe_if.sv @@
// ---------------------------------------------------------------------------
// Masked window energy channels
// Valid/ready channels for input pixels and energy results.
// ---------------------------------------------------------------------------
interface mwe_in_if import mwe_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] detail;
  logic signed [COEF_WIDTH-1:0] coarser;
  logic                         in_sector;
  modport source(output valid, detail, coarser, in_sector, input ready);
  modport sink(input valid, detail, coarser, in_sector, output ready);
endinterface

interface mwe_out_if import mwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] energy;
  logic [ROW_W-1:0]  center_row;
  logic [COL_W-1:0]  center_col;
  modport source(output valid, energy, center_row, center_col, input ready);
  modport sink(input valid, energy, center_row, center_col, output ready);
endinterface

@@ rtl/mwe_fifo.sv @@
// ---------------------------------------------------------------------------
// Masked window energy job queue
// Two-entry queue of window jobs between the front and back parts.
// ---------------------------------------------------------------------------
module mwe_fifo import mwe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  assign head_job = slot_r[rp_r];
  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);

endmodule

@@ rtl/mwe_front.sv @@
// ---------------------------------------------------------------------------
// Masked window energy front part
// Holds configuration, scans raster position, writes lines, issues jobs.
// ---------------------------------------------------------------------------
module mwe_front import mwe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mwe_in_if.sink               in_ch,
  input  logic                 busy,
  output logic                 job_push,
  output job_t                 job,
  output mem_wr_t              wr
);

  logic [CFG_W-1:0]  num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0]  num_cols_r, num_cols_nxt;
  logic [HW_W-1:0]   half_window_r, half_window_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [CFG_W-1:0]  rows, cols, col_inc, row_inc;
  logic [HW_W-1:0]   h;
  logic [LINE_W-1:0] two_h;
  logic              accept;

  always_comb begin
    num_rows_nxt    = num_rows_r;
    num_cols_nxt    = num_cols_r;
    half_window_nxt = half_window_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS:    num_rows_nxt    = cfg_data;
        CFG_NUM_COLS:    num_cols_nxt    = cfg_data;
        CFG_HALF_WINDOW: half_window_nxt = cfg_data[HW_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows   = cfg_limit(num_rows_r, MAX_ROWS);
  assign cols   = cfg_limit(num_cols_r, MAX_COLS);
  assign h      = (half_window_r > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW)
                                                           : half_window_r;
  assign two_h  = LINE_W'({h, 1'b0});
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy;

  assign col_inc = CFG_W'(col_r) + CFG_W'(1);
  assign row_inc = CFG_W'(row_r) + CFG_W'(1);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    line_nxt = line_r;
    if (accept) begin
      if (col_inc >= cols) begin
        col_nxt = '0;
        if (row_inc >= rows) begin
          row_nxt  = '0;
          line_nxt = '0;
        end else begin
          row_nxt  = row_inc[ROW_W-1:0];
          line_nxt = line_add(line_r, LINE_W'(1));
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r    <= CFG_W'(MAX_ROWS);
      num_cols_r    <= CFG_W'(MAX_COLS);
      half_window_r <= HW_W'(1);
      row_r         <= '0;
      col_r         <= '0;
      line_r        <= '0;
    end else begin
      num_rows_r    <= num_rows_nxt;
      num_cols_r    <= num_cols_nxt;
      half_window_r <= half_window_nxt;
      row_r         <= row_nxt;
      col_r         <= col_nxt;
      line_r        <= line_nxt;
    end
  end

  always_comb begin
    job_push     = accept && (row_r >= ROW_W'(two_h)) && (col_r >= COL_W'(two_h));
    job.top_line = line_add(line_r, LINE_W'(LINES) - two_h);
    job.left_col = col_r - COL_W'(two_h);
    job.h        = h;
    job.crow     = row_r - ROW_W'(h);
    job.ccol     = col_r - COL_W'(h);
    wr.we        = accept;
    wr.addr      = mem_addr(line_r, col_r);
    wr.detail    = in_ch.detail;
    wr.coarser   = in_ch.coarser;
    wr.sector    = in_ch.in_sector;
  end

endmodule

@@ rtl/mwe_back.sv @@
// ---------------------------------------------------------------------------
// Masked window energy back part
// Line memories, window square sum, divider, square root and result register.
// ---------------------------------------------------------------------------
module mwe_back import mwe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mem_wr_t wr,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_pop,
  output logic    busy,
  mwe_out_if.source out_ch
);

  logic signed [COEF_WIDTH-1:0] det_mem [DEPTH];
  logic [COEF_WIDTH:0]          ctr_mem [DEPTH];
  logic signed [COEF_WIDTH-1:0] det_q_r;
  logic [COEF_WIDTH:0]          ctr_q_r;
  logic [ADDR_W-1:0]            rd_addr;

  back_state_t                  state_r, state_nxt;
  job_t                         job_r;
  logic [WIN_W-1:0]             u_r, v_r, last;
  logic [LINE_W-1:0]            cur_line_r;
  logic                         rdv_r, sqv_r;
  logic signed [COEF_WIDTH-1:0] mul_a, ctr_det_r, ctr_coa_r;
  logic signed [SQ_W-1:0]       prod;
  logic [SQ_W-1:0]              sq_r;
  logic [ACC_W-1:0]             acc_r;
  logic [ACC_W-1:0]             div_q_r, div_q_nxt;
  logic [DIVS_W-1:0]            div_rem_r, div_rem_nxt, divisor;
  logic [DIVS_W:0]              trial;
  logic [STEP_W-1:0]            step_r;
  logic [Q_W-1:0]               n_r, root_r, bit_r, rb;
  logic                         out_valid_r, out_load;
  logic [ROOT_W-1:0]            out_energy_r;
  logic [ROW_W-1:0]             out_row_r;
  logic [COL_W-1:0]             out_col_r;

  assign last    = WIN_W'({job_r.h, 1'b0});
  assign divisor = side_sq(job_r.h);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:    if (job_valid) state_nxt = BK_CTR_RD;
      BK_CTR_RD:  state_nxt = BK_CTR_CHK;
      BK_CTR_CHK: state_nxt = ctr_q_r[0] ? BK_SUM : BK_IDLE;
      BK_SUM:     if (u_r == last && v_r == last) state_nxt = BK_DRAIN;
      BK_DRAIN:   if (!rdv_r && !sqv_r) state_nxt = BK_FIX1;
      BK_FIX1:    state_nxt = BK_FIX2;
      BK_FIX2:    state_nxt = BK_FIX3;
      BK_FIX3:    state_nxt = BK_DIV;
      BK_DIV:     if (step_r == STEP_W'(ACC_W - 1)) state_nxt = BK_SQRT;
      BK_SQRT:    if (bit_r == '0) state_nxt = BK_OUT;
      BK_OUT:     if (!out_valid_r || out_ch.ready) state_nxt = BK_IDLE;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (state_r == BK_IDLE) && job_valid;
    busy     = (state_r != BK_IDLE);
    out_load = (state_r == BK_OUT) && (!out_valid_r || out_ch.ready);
    if (state_r == BK_CTR_RD) begin
      rd_addr = mem_addr(line_add(job_r.top_line, LINE_W'(job_r.h)), job_r.ccol);
    end else begin
      rd_addr = mem_addr(cur_line_r, job_r.left_col + COL_W'(v_r));
    end
    unique case (state_r)
      BK_FIX1: mul_a = ctr_coa_r;
      BK_FIX2: mul_a = ctr_det_r;
      default: mul_a = det_q_r;
    endcase
  end

  assign prod  = mul_a * mul_a;
  assign trial = {div_rem_r, div_q_r[ACC_W-1]};
  assign rb    = root_r + bit_r;

  always_comb begin
    div_q_nxt   = {div_q_r[ACC_W-2:0], 1'b0};
    div_rem_nxt = trial[DIVS_W-1:0];
    if (trial >= {1'b0, divisor}) begin
      div_q_nxt[0] = 1'b1;
      div_rem_nxt  = DIVS_W'(trial - {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      det_mem[wr.addr] <= wr.detail;
      ctr_mem[wr.addr] <= {wr.coarser, wr.sector};
    end
    det_q_r <= det_mem[rd_addr];
    ctr_q_r <= ctr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rdv_r       <= 1'b0;
      sqv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == BK_SUM);
      sqv_r   <= rdv_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= prod;
    if (job_pop) begin
      job_r <= job;
    end
    unique case (state_r)
      BK_CTR_RD: begin
        acc_r      <= '0;
        u_r        <= '0;
        v_r        <= '0;
        cur_line_r <= job_r.top_line;
      end
      BK_CTR_CHK: begin
        ctr_det_r <= $signed(ctr_q_r[COEF_WIDTH:1]) == det_q_r ? det_q_r : det_q_r;
        ctr_coa_r <= ctr_q_r[COEF_WIDTH:1];
      end
      BK_SUM: begin
        if (v_r == last) begin
          v_r        <= '0;
          u_r        <= u_r + WIN_W'(1);
          cur_line_r <= line_add(cur_line_r, LINE_W'(1));
        end else begin
          v_r <= v_r + WIN_W'(1);
        end
      end
      BK_FIX2: acc_r <= acc_r + ACC_W'(sq_r);
      BK_FIX3: begin
        div_q_r   <= acc_r - ACC_W'(sq_r);
        div_rem_r <= '0;
        step_r    <= '0;
      end
      BK_DIV: begin
        div_q_r   <= div_q_nxt;
        div_rem_r <= div_rem_nxt;
        step_r    <= step_r + STEP_W'(1);
        n_r       <= div_q_nxt[Q_W-1:0];
        root_r    <= '0;
        bit_r     <= Q_W'(1) << (Q_W - 2);
      end
      BK_SQRT: begin
        if (bit_r != '0) begin
          if (n_r >= rb) begin
            n_r    <= n_r - rb;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      default: ;
    endcase
    if (sqv_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
    if (out_load) begin
      out_energy_r <= root_r[ROOT_W-1:0];
      out_row_r    <= job_r.crow;
      out_col_r    <= job_r.ccol;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.energy     = out_energy_r;
  assign out_ch.center_row = out_row_r;
  assign out_ch.center_col = out_col_r;

endmodule

@@ rtl/masked_window_energy_unit.sv @@
// ---------------------------------------------------------------------------
// Masked window energy unit
// Local RMS energy over a (2H+1) square window for masked interior centres.
//
// Channel  Direction  Carries
// in_ch    in         detail, coarser, in_sector per raster pixel
// out_ch   out        energy, center_row, center_col per masked centre
// cfg_*    in         num_rows, num_cols, half_window register writes
//
// A border pixel issues no window job; an interior pixel with a clear mask bit ends its job at the centre check.
// A masked interior centre makes one memory read per window pixel, then runs a
// 39-step divider and a 16-step root.
// Reset is synchronous; the line memories are not cleared.
// A waiting result in the output register does not stop new transactions.
// The next result waits in its last step until the output register is free.
// ---------------------------------------------------------------------------
`include "masked_window_energy_unit_defines.svh"

module masked_window_energy_unit import mwe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mwe_in_if.sink               in_ch,
  mwe_out_if.source            out_ch
);

  job_t    push_job, head_job;
  mem_wr_t wr;
  logic    job_push, job_pop, fifo_empty, fifo_full, back_busy;

  mwe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .busy      (back_busy || !fifo_empty),
    .job_push  (job_push),
    .job       (push_job),
    .wr        (wr)
  );

  mwe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  mwe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .job_valid (!fifo_empty),
    .job       (head_job),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .out_ch    (out_ch)
  );

  `MWE_ASSERT_NOW(a_push_room, job_push, !fifo_full, "Job pushed into a full queue.")
  `MWE_ASSERT_NOW(a_accept_quiet, in_ch.valid && in_ch.ready, !back_busy && fifo_empty, "Pixel taken while a job was open.")
  `MWE_ASSERT_NEXT(a_pop_starts, job_pop, back_busy, "Popped job did not start the back part.")

endmodule
